// ----- rtl/core/fixed_ascii_coord_frame_parser_assert.svh -----
// Assertion macros used by the frame parser checker.
`ifndef FIXED_ASCII_COORD_FRAME_PARSER_ASSERT_SVH
`define FIXED_ASCII_COORD_FRAME_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define FACP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("frame parser assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define FACP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("frame parser assertion failed");

`endif

// ----- rtl/core/facp_pkg.sv -----
// Types and constants of the fixed ASCII coordinate frame parser.
package facp_pkg;

  localparam int unsigned NFIELDS   = 4;
  localparam int unsigned MAG_W     = 17;
  localparam int unsigned VAL_W     = 18;
  localparam int unsigned CFG_W     = 6;
  localparam int unsigned MAX_FRAME = 63;

  localparam logic [MAG_W-1:0] MAG_LIMIT = 17'd99999;

  localparam logic [7:0] CHR_X     = 8'h58;
  localparam logic [7:0] CHR_Y     = 8'h59;
  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_0     = 8'h30;
  localparam logic [7:0] CHR_9     = 8'h39;

  // Marker byte positions and characters: pos x, pos y, speed x, speed y
  localparam logic [7:0] MARKER_POS [NFIELDS] = '{8'd2, 8'd9, 8'd16, 8'd23};
  localparam logic [7:0] MARKER_CHR [NFIELDS] = '{CHR_X, CHR_Y, CHR_X, CHR_Y};

  // Register indexes on the configuration port
  localparam logic REG_EXPECTED_LENGTH = 1'b0;
  localparam logic REG_SPEED_SIGNED    = 1'b1;

  localparam logic [CFG_W-1:0] EXP_LEN_RESET = 6'd30;

  // Per-field parse state within the current frame
  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             neg;
    logic             seen;
    logic             open;
  } field_st_t;

endpackage

// ----- rtl/core/facp_field.sv -----
// Next-state logic of one field's parse state for one received byte.
module facp_field (
  input  logic [7:0]           pos_i,
  input  logic [7:0]           rx_byte_i,
  input  logic [7:0]           marker_pos_i,
  input  logic [7:0]           marker_chr_i,
  input  facp_pkg::field_st_t  st_i,
  output facp_pkg::field_st_t  st_o
);

  facp_pkg::field_st_t   cur;
  logic                  is_digit;
  logic [3:0]            digit;
  logic [19:0]           acc;

  // Digit accumulate: times ten plus digit, worst case 999999 fits 20 bits
  assign is_digit = (rx_byte_i >= facp_pkg::CHR_0) && (rx_byte_i <= facp_pkg::CHR_9);
  assign digit    = 4'(rx_byte_i - facp_pkg::CHR_0);
  assign acc      = 20'(st_i.mag) * 20'd10 + 20'(digit);

  always_comb begin
    // first byte of a frame starts from a clean field
    cur = (pos_i == 8'd0) ? '0 : st_i;
    st_o = cur;
    if (pos_i == marker_pos_i) begin
      st_o.seen = (rx_byte_i == marker_chr_i);
      st_o.open = 1'b0;
      st_o.mag  = '0;
      st_o.neg  = 1'b0;
    end else if (pos_i == marker_pos_i + 8'd1) begin
      st_o.neg  = (rx_byte_i == facp_pkg::CHR_MINUS);
      st_o.open = 1'b1;
    end else if ((pos_i > marker_pos_i + 8'd1) && cur.open) begin
      if (is_digit) begin
        st_o.mag = (acc > 20'(facp_pkg::MAG_LIMIT)) ? facp_pkg::MAG_LIMIT
                                                    : acc[facp_pkg::MAG_W-1:0];
      end else begin
        st_o.open = 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/fixed_ascii_coord_frame_parser.sv -----
// Top level of the fixed ASCII coordinate frame parser.
// Takes one received byte per beat and gives one result beat per frame, on the byte flagged
// frame_end. The per-field digit accumulators update in the cycle the byte is accepted, and
// a frame end loads the result register in that same cycle. Bytes keep flowing while a
// result waits; only a frame-end byte stalls until the held result has been taken. Fields
// sit at fixed positions: 'X' at 2 and 16, 'Y' at 9 and 23, each followed by a sign byte
// and a decimal run that saturates at 99999. A frame whose length equals expected_length
// commits each field whose marker matched; otherwise status is 1 and the held values stay.
// Bytes past MAX_FRAME are dropped and mark the frame long.
module fixed_ascii_coord_frame_parser #(
  parameter int unsigned MAX_FRAME = facp_pkg::MAX_FRAME
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [facp_pkg::CFG_W-1:0]  cfg_wdata_i,
  // byte input
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  rx_byte_i,
  input  logic                        frame_end_i,
  // result output
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        status_o,
  output logic [3:0]                  fields_updated_o,
  output logic signed [facp_pkg::VAL_W-1:0] pos_x_o,
  output logic signed [facp_pkg::VAL_W-1:0] pos_y_o,
  output logic signed [facp_pkg::VAL_W-1:0] speed_x_o,
  output logic signed [facp_pkg::VAL_W-1:0] speed_y_o
);

  localparam int unsigned IDX_W = $clog2(MAX_FRAME + 1);
  localparam int unsigned CMP_W = (IDX_W > facp_pkg::CFG_W) ? IDX_W : facp_pkg::CFG_W;
  localparam int unsigned NF    = facp_pkg::NFIELDS;
  localparam int unsigned VW    = facp_pkg::VAL_W;

  logic [facp_pkg::CFG_W-1:0] exp_len_q;
  logic                       spd_signed_q;

  logic [IDX_W-1:0]           idx_q;
  logic [IDX_W-1:0]           idx_d;
  facp_pkg::field_st_t        fld_q [NF];
  facp_pkg::field_st_t        fld_d [NF];
  logic [VW-1:0]              held_q [NF];
  logic [VW-1:0]              held_d [NF];

  logic                       out_valid_q;
  logic                       status_q;
  logic [NF-1:0]              upd_q;
  logic [VW-1:0]              res_q [NF];

  logic                       accept;
  logic                       too_long;
  logic [IDX_W-1:0]           len;
  logic                       len_ok;
  logic [NF-1:0]              upd_d;

  // Bytes that end no frame never need the output slot
  assign in_ready_o = !out_valid_q || out_ready_i || !frame_end_i;
  assign accept     = in_valid_i && in_ready_o;

  assign too_long = (idx_q >= IDX_W'(MAX_FRAME));
  assign len      = idx_q + IDX_W'(1);
  assign len_ok   = !too_long && (CMP_W'(len) == CMP_W'(exp_len_q));
  assign idx_d    = frame_end_i ? '0 : (too_long ? idx_q : len);

  // Per-field parse logic
  for (genvar f = 0; f < NF; f++) begin : g_field
    facp_field u_field (
      .pos_i        (8'(idx_q)),
      .rx_byte_i    (rx_byte_i),
      .marker_pos_i (facp_pkg::MARKER_POS[f]),
      .marker_chr_i (facp_pkg::MARKER_CHR[f]),
      .st_i         (fld_q[f]),
      .st_o         (fld_d[f])
    );

    // Commit: sign applies to positions always, to speeds only when enabled
    always_comb begin
      logic neg;
      neg       = fld_d[f].neg && ((f < 2) || spd_signed_q);
      upd_d[f]  = len_ok && fld_d[f].seen;
      held_d[f] = held_q[f];
      if (upd_d[f]) begin
        held_d[f] = neg ? (VW'(0) - VW'(fld_d[f].mag)) : VW'(fld_d[f].mag);
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_len_q    <= facp_pkg::EXP_LEN_RESET;
      spd_signed_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        facp_pkg::REG_EXPECTED_LENGTH: exp_len_q    <= cfg_wdata_i;
        facp_pkg::REG_SPEED_SIGNED:    spd_signed_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Frame state and held values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      for (int f = 0; f < NF; f++) begin
        fld_q[f]  <= '0;
        held_q[f] <= '0;
      end
    end else if (accept) begin
      idx_q <= idx_d;
      if (!too_long) begin
        fld_q <= fld_d;
      end
      if (frame_end_i) begin
        held_q <= held_d;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && frame_end_i) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && frame_end_i) begin
      status_q <= !len_ok;
      upd_q    <= upd_d;
      res_q    <= held_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign fields_updated_o = upd_q;
  assign pos_x_o          = res_q[0];
  assign pos_y_o          = res_q[1];
  assign speed_x_o        = res_q[2];
  assign speed_y_o        = res_q[3];

endmodule

// ----- rtl/core/facp_checker.sv -----
// Port-level checks of the frame parser, bound to the top level.
`include "fixed_ascii_coord_frame_parser_assert.svh"

module facp_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      frame_end_i,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic                      status_o,
  input logic [3:0]                fields_updated_o,
  input logic [facp_pkg::VAL_W-1:0] pos_x_o
);

  logic out_stall;

  assign out_stall = out_valid_o && !out_ready_i;

  // A stalled result beat holds
  `FACP_ASSERT_NEXT(a_out_hold, out_stall, out_valid_o && $stable(pos_x_o) && $stable(fields_updated_o))
  // A rejected frame commits nothing
  `FACP_ASSERT_NOW(a_reject_no_update, out_valid_o && status_o, fields_updated_o == 4'd0)
  // An accepted frame-end byte yields a result beat next cycle
  `FACP_ASSERT_NEXT(a_end_gives_result, in_valid_i && in_ready_o && frame_end_i, out_valid_o)
  // Input only stalls on a frame end behind an untaken result
  `FACP_ASSERT_NOW(a_stall_cause, !in_ready_o, out_stall && frame_end_i)

endmodule

bind fixed_ascii_coord_frame_parser facp_checker u_facp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .frame_end_i      (frame_end_i),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .status_o         (status_o),
  .fields_updated_o (fields_updated_o),
  .pos_x_o          (pos_x_o)
);

// ----- sim/fixed_ascii_coord_frame_parser_tb.sv -----
// Self-checking testbench for the fixed ASCII coordinate frame parser.
`timescale 1ns / 100ps

module fixed_ascii_coord_frame_parser_tb;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned PHASE_BYTES  = 110;
  localparam int unsigned NUM_PHASES   = 8;

  // Phase settings: length and speed sign handling, extremes included
  localparam logic [facp_pkg::CFG_W-1:0] PHASE_LEN [NUM_PHASES] =
    '{6'd30, 6'd63, 6'd63, 6'd1, 6'd0, 6'd12, 6'd24, 6'd30};
  localparam bit PHASE_SGN [NUM_PHASES] =
    '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};

  // One result beat as seen on the output port
  typedef struct packed {
    logic                              status;
    logic [3:0]                        updated;
    logic signed [facp_pkg::VAL_W-1:0] pos_x;
    logic signed [facp_pkg::VAL_W-1:0] pos_y;
    logic signed [facp_pkg::VAL_W-1:0] speed_x;
    logic signed [facp_pkg::VAL_W-1:0] speed_y;
  } coord_result_t;

  // Tracks the parser's frame state and the results it owes
  class frame_tracker;
    logic [facp_pkg::CFG_W-1:0]        exp_len;
    bit                                spd_signed;
    int unsigned                       byte_idx;
    logic [facp_pkg::MAG_W-1:0]        mag     [facp_pkg::NFIELDS];
    bit                                neg     [facp_pkg::NFIELDS];
    bit                                seen    [facp_pkg::NFIELDS];
    bit                                open    [facp_pkg::NFIELDS];
    logic signed [facp_pkg::VAL_W-1:0] held    [facp_pkg::NFIELDS];
    coord_result_t                     due_results [$];
    int unsigned                       n_bytes, n_results, n_decoded, n_rejected;
    int unsigned                       n_saturated, n_settings, n_errors;

    function new();
      exp_len    = facp_pkg::EXP_LEN_RESET;
      spd_signed = 1'b0;
      byte_idx   = 0;
      for (int f = 0; f < facp_pkg::NFIELDS; f++) begin
        mag[f]  = '0;
        neg[f]  = 1'b0;
        seen[f] = 1'b0;
        open[f] = 1'b0;
        held[f] = '0;
      end
    endfunction

    function void set_reg(logic idx, logic [facp_pkg::CFG_W-1:0] val);
      if (idx == facp_pkg::REG_EXPECTED_LENGTH) exp_len = val;
      else spd_signed = val[0];
      n_settings++;
    endfunction

    // Per-field scan of one byte at its frame position
    function void scan_byte(logic [7:0] b);
      int unsigned m;
      int          v;
      for (int f = 0; f < facp_pkg::NFIELDS; f++) begin
        m = facp_pkg::MARKER_POS[f];
        if (byte_idx == 0) begin
          seen[f] = 1'b0;
          open[f] = 1'b0;
          mag[f]  = '0;
          neg[f]  = 1'b0;
        end
        if (byte_idx == m) begin
          seen[f] = (b == facp_pkg::MARKER_CHR[f]);
          open[f] = 1'b0;
          mag[f]  = '0;
          neg[f]  = 1'b0;
        end else if (byte_idx == m + 1) begin
          neg[f]  = (b == facp_pkg::CHR_MINUS);
          open[f] = 1'b1;
        end else if (byte_idx > m + 1 && open[f]) begin
          if (b >= facp_pkg::CHR_0 && b <= facp_pkg::CHR_9) begin
            v = int'(mag[f]) * 10 + int'(b - facp_pkg::CHR_0);
            mag[f] = (v > int'(facp_pkg::MAG_LIMIT)) ? facp_pkg::MAG_LIMIT
                                                     : v[facp_pkg::MAG_W-1:0];
          end else begin
            open[f] = 1'b0;
          end
        end
      end
    endfunction

    // Accepted input beat: advance the frame and queue a result on frame end
    function void apply_byte(logic [7:0] b, bit last);
      bit            too_long;
      int unsigned   len;
      bit            sub;
      coord_result_t r;
      too_long = 1'b0;
      len      = 0;
      n_bytes++;
      if (byte_idx < facp_pkg::MAX_FRAME) begin
        scan_byte(b);
        byte_idx++;
        len = byte_idx;
      end else begin
        too_long = 1'b1;
      end
      if (!last) return;
      r.updated = '0;
      if (!too_long && len == exp_len) begin
        r.status = 1'b0;
        n_decoded++;
        for (int f = 0; f < facp_pkg::NFIELDS; f++) begin
          if (seen[f]) begin
            sub = neg[f] && (f < 2 || spd_signed);
            held[f] = sub ? -$signed({1'b0, mag[f]}) : $signed({1'b0, mag[f]});
            r.updated[f] = 1'b1;
            if (mag[f] == facp_pkg::MAG_LIMIT) n_saturated++;
          end
        end
      end else begin
        r.status = 1'b1;
        n_rejected++;
      end
      r.pos_x   = held[0];
      r.pos_y   = held[1];
      r.speed_x = held[2];
      r.speed_y = held[3];
      byte_idx  = 0;
      due_results.push_back(r);
    endfunction

    function void cmp_field(string what, int want, int got);
      if (want != got) begin
        n_errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
    endfunction

    // Accepted result beat: compare with the oldest owed result
    function void take_result(coord_result_t got);
      coord_result_t want;
      n_results++;
      if (due_results.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result beat, expected none, actual status %0d mask %0h",
                 $time, got.status, got.updated);
        return;
      end
      want = due_results.pop_front();
      cmp_field("status", want.status, got.status);
      cmp_field("fields_updated", want.updated, got.updated);
      cmp_field("pos_x", want.pos_x, got.pos_x);
      cmp_field("pos_y", want.pos_y, got.pos_y);
      cmp_field("speed_x", want.speed_x, got.speed_x);
      cmp_field("speed_y", want.speed_y, got.speed_y);
    endfunction
  endclass

  logic                              clk_i;
  logic                              rst_ni;
  logic                              cfg_we_i;
  logic                              cfg_idx_i;
  logic [facp_pkg::CFG_W-1:0]        cfg_wdata_i;
  logic                              in_valid_i;
  logic                              in_ready_o;
  logic [7:0]                        rx_byte_i;
  logic                              frame_end_i;
  logic                              out_valid_o;
  logic                              out_ready_i;
  logic                              status_o;
  logic [3:0]                        fields_updated_o;
  logic signed [facp_pkg::VAL_W-1:0] pos_x_o;
  logic signed [facp_pkg::VAL_W-1:0] pos_y_o;
  logic signed [facp_pkg::VAL_W-1:0] speed_x_o;
  logic signed [facp_pkg::VAL_W-1:0] speed_y_o;

  frame_tracker tracker;
  int unsigned  cycles = 0;
  int unsigned  burst_left;
  int unsigned  hold_reqs;

  fixed_ascii_coord_frame_parser dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .rx_byte_i        (rx_byte_i),
    .frame_end_i      (frame_end_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .fields_updated_o (fields_updated_o),
    .pos_x_o          (pos_x_o),
    .pos_y_o          (pos_y_o),
    .speed_x_o        (speed_x_o),
    .speed_y_o        (speed_y_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Result monitor and run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && out_ready_i) begin
      tracker.take_result('{status_o, fields_updated_o, pos_x_o, pos_y_o,
                            speed_x_o, speed_y_o});
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: run limit reached with %0d results still owed",
               $time, tracker.due_results.size());
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: changing stall patterns, plus a long hold-off on request
  initial begin
    int unsigned hold_cnt;
    int unsigned hold_seen;
    int unsigned mode;
    int unsigned mode_left;
    hold_cnt  = 0;
    hold_seen = 0;
    mode      = 0;
    mode_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready_i <= 1'b0;
      end else if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_cnt  = HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else begin
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= cycles[1];
        endcase
      end
    end
  end

  // Offer one beat; the sender may idle between bursts of random length
  task automatic send_byte(logic [7:0] b, bit last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if ($urandom_range(0, 15) == 0) gap = $urandom_range(10, 30);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 48);
    end
    in_valid_i  <= 1'b1;
    rx_byte_i   <= b;
    frame_end_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.apply_byte(b, last);
    burst_left--;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  // Sender pause until every owed result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Both registers, written back to back while the parser is idle
  task automatic set_config(logic [facp_pkg::CFG_W-1:0] len, bit sgn);
    logic [facp_pkg::CFG_W-1:0] sgn_word;
    sgn_word = {5'($urandom_range(0, 31)), sgn};
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= facp_pkg::REG_EXPECTED_LENGTH;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    tracker.set_reg(facp_pkg::REG_EXPECTED_LENGTH, len);
    cfg_idx_i   <= facp_pkg::REG_SPEED_SIGNED;
    cfg_wdata_i <= sgn_word;
    @(posedge clk_i);
    tracker.set_reg(facp_pkg::REG_SPEED_SIGNED, sgn_word);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] digit_byte();
    return facp_pkg::CHR_0 + 8'($urandom_range(0, 9));
  endfunction

  // Frame of the given length: mostly digits, markers and signs at their slots
  task automatic send_frame(int unsigned len);
    logic [7:0]  fb [$];
    int unsigned m;
    int unsigned r;
    bit          long_tail;
    long_tail = (len > 30) ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (long_tail && i > 24) fb.push_back(digit_byte());
      else if (r < 65) fb.push_back(digit_byte());
      else if (r < 75) fb.push_back(",");
      else if (r < 80) fb.push_back(" ");
      else fb.push_back(8'($urandom_range(0, 255)));
    end
    for (int f = 0; f < facp_pkg::NFIELDS; f++) begin
      m = facp_pkg::MARKER_POS[f];
      if (m < len)
        fb[m] = ($urandom_range(0, 9) != 0) ? facp_pkg::MARKER_CHR[f]
                                            : 8'($urandom_range(0, 255));
      if (m + 1 < len) begin
        r = $urandom_range(0, 99);
        fb[m + 1] = (r < 45) ? facp_pkg::CHR_MINUS : (r < 80) ? "+"
                                                   : 8'($urandom_range(0, 255));
      end
    end
    for (int i = 0; i < len; i++) send_byte(fb[i], i == len - 1);
  endtask

  // Random bytes with random frame ends
  task automatic send_noise(int unsigned n);
    for (int i = 0; i < n; i++)
      send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
  endtask

  task automatic run_phase(int unsigned budget);
    int unsigned start;
    int unsigned r;
    int          len;
    start = tracker.n_bytes;
    while (tracker.n_bytes - start < budget) begin
      r   = $urandom_range(0, 99);
      len = (tracker.exp_len == 0) ? int'($urandom_range(1, 30)) : int'(tracker.exp_len);
      if (r < 10) begin
        send_noise($urandom_range(1, 20));
      end else begin
        if (r >= 70 && r < 82) len = len + int'($urandom_range(0, 4)) - 2;
        else if (r >= 82 && r < 94) len = int'($urandom_range(1, 40));
        else if (r >= 94) len = int'($urandom_range(64, 72));
        if (len < 1) len = 1;
        send_frame(len);
      end
    end
    drain();
  endtask

  // Stimulus
  initial begin
    tracker     = new();
    burst_left  = 0;
    hold_reqs   = 0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = facp_pkg::REG_EXPECTED_LENGTH;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    rx_byte_i   = '0;
    frame_end_i = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: full-scale magnitudes, unknown sign, leading zeros, dropped speed
    // sign, then wrong-length frames of one byte and a short frame
    send_text("  X-99999Ya00012X-12345Y+67890");
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    send_text("  X-7");
    drain();

    // Random phases through the setting table
    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      set_config(PHASE_LEN[ph], PHASE_SGN[ph]);
      // Long receiver hold-off while the sender keeps going
      if (ph == 0) hold_reqs++;
      run_phase(PHASE_BYTES);
    end

    drain();
    repeat (10) @(posedge clk_i);
    $display("covered %0d bytes and %0d frames (%0d decoded, %0d rejected) over %0d settings",
             tracker.n_bytes, tracker.n_results, tracker.n_decoded, tracker.n_rejected,
             tracker.n_settings / 2);
    $display("saturated field commits: %0d, mismatches: %0d",
             tracker.n_saturated, tracker.n_errors);
    if (tracker.n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/facp_pkg.sv
rtl/core/facp_field.sv
rtl/core/fixed_ascii_coord_frame_parser.sv
rtl/core/facp_checker.sv
sim/fixed_ascii_coord_frame_parser_tb.sv
